// ----- sv/sgl3d_pkg.sv -----
// Package with the shared constants and register codes of the 3D gradient and Laplacian stencil.
package sgl3d_pkg;

  localparam int unsigned XW      = 12;
  localparam int unsigned CMPW    = 14;
  localparam int unsigned SXW     = 13;
  localparam int unsigned SYW     = 7;
  localparam int unsigned SZW     = 7;
  localparam int unsigned MGW     = 4;
  localparam int unsigned NCW     = 3;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 13;
  localparam int unsigned SX_MAX  = 4096;
  localparam int unsigned MG_MAX  = 8;

  typedef enum logic [CFG_AW-1:0] {
    CFG_SIZE_X     = 3'd0,
    CFG_SIZE_Y     = 3'd1,
    CFG_SIZE_Z     = 3'd2,
    CFG_MARGIN     = 3'd3,
    CFG_COMPONENTS = 3'd4
  } cfg_idx_t;

endpackage

// ----- sv/stencil_gradient_laplacian_3d.sv -----
// Top level of the streaming seven-point gradient and Laplacian stencil over a 3D grid.
// The block takes one sample per clock cycle while the output is not stalled; each result
// passes stage A, stage B and the output register, and a stalled output holds the whole
// pipeline. That rate comes from the plane buffer, split by row parity into two memories,
// each with two read ports and one write port, so that every cycle reads the x-minus, y and
// z-plus neighbors; the center and the z-minus value come from two short delay lines. The
// buffer needs no clearing pass after reset, but a grid must be streamed from its first sample.
module stencil_gradient_laplacian_3d #(
  parameter int unsigned MAX_Y          = 64,
  parameter int unsigned MAX_Z          = 64,
  parameter int unsigned MAX_COMPONENTS = 4,
  parameter int unsigned SAMPLE_WIDTH   = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sgl3d_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [sgl3d_pkg::CFG_DW-1:0]        cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0: sample.
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   in_tdata,
  // Fields from bit 0: start_req.
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0: pos_x, pos_y, pos_z, component, grad_x, grad_y, grad_z, laplacian.
  output logic [((sgl3d_pkg::XW + $clog2(MAX_Y) + $clog2(MAX_Z)
                  + ((MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1)
                  + 4*SAMPLE_WIDTH + 7 + 7)/8)*8-1:0] out_tdata,
  output logic                                out_tlast
);

  localparam int unsigned SW   = SAMPLE_WIDTH;
  localparam int unsigned XW   = sgl3d_pkg::XW;
  localparam int unsigned YW   = $clog2(MAX_Y);
  localparam int unsigned ZW   = $clog2(MAX_Z);
  localparam int unsigned CW   = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int unsigned YHW  = YW - 1;
  localparam int unsigned AW   = 1 + YHW + ZW + CW;
  localparam int unsigned DEP  = 2 ** AW;
  localparam int unsigned OBW  = XW + YW + ZW + CW + 4*SW + 7;
  localparam int unsigned OW   = ((OBW + 7)/8)*8;
  localparam int unsigned CMPW = sgl3d_pkg::CMPW;

  // Configuration registers.
  logic [sgl3d_pkg::SXW-1:0] size_x_r;
  logic [sgl3d_pkg::SYW-1:0] size_y_r;
  logic [sgl3d_pkg::SZW-1:0] size_z_r;
  logic [sgl3d_pkg::MGW-1:0] margin_r;
  logic [sgl3d_pkg::NCW-1:0] comps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= sgl3d_pkg::SXW'(3);
      size_y_r <= sgl3d_pkg::SYW'(3);
      size_z_r <= sgl3d_pkg::SZW'(3);
      margin_r <= sgl3d_pkg::MGW'(1);
      comps_r  <= sgl3d_pkg::NCW'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        sgl3d_pkg::CFG_SIZE_X:     size_x_r <= cfg_wdata[sgl3d_pkg::SXW-1:0];
        sgl3d_pkg::CFG_SIZE_Y:     size_y_r <= cfg_wdata[sgl3d_pkg::SYW-1:0];
        sgl3d_pkg::CFG_SIZE_Z:     size_z_r <= cfg_wdata[sgl3d_pkg::SZW-1:0];
        sgl3d_pkg::CFG_MARGIN:     margin_r <= cfg_wdata[sgl3d_pkg::MGW-1:0];
        sgl3d_pkg::CFG_COMPONENTS: comps_r  <= cfg_wdata[sgl3d_pkg::NCW-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [CMPW-1:0] clampv(logic [CMPW-1:0] v, logic [CMPW-1:0] lo,
                                             logic [CMPW-1:0] hi);
    logic [CMPW-1:0] r;
    r = (v < lo) ? lo : ((v > hi) ? hi : v);
    return r;
  endfunction

  logic [CMPW-1:0] sx, sy, sz, mg, nc;
  always_comb begin
    sx = clampv(CMPW'(size_x_r), CMPW'(3), CMPW'(sgl3d_pkg::SX_MAX));
    sy = clampv(CMPW'(size_y_r), CMPW'(3), CMPW'(MAX_Y));
    sz = clampv(CMPW'(size_z_r), CMPW'(3), CMPW'(MAX_Z));
    mg = clampv(CMPW'(margin_r), CMPW'(1), CMPW'(sgl3d_pkg::MG_MAX));
    nc = clampv(CMPW'(comps_r), CMPW'(1), CMPW'(MAX_COMPONENTS));
  end

  logic en, acc;
  logic out_v_r;
  assign en        = !out_v_r || out_tready;
  assign in_tready = en;
  assign acc       = in_tvalid && en;

  // Input position.
  logic [XW-1:0] x_r, x_nxt, px;
  logic [YW-1:0] y_r, y_nxt, py;
  logic [ZW-1:0] z_r, z_nxt, pz;
  logic [CW-1:0] c_r, c_nxt, pc;
  logic [SW-1:0] s;
  logic [CMPW-1:0] cx, x14, y14, z14, c14;
  logic emit, last, par;

  always_comb begin
    s   = in_tdata[SW-1:0];
    px  = in_tuser ? '0 : x_r;
    py  = in_tuser ? '0 : y_r;
    pz  = in_tuser ? '0 : z_r;
    pc  = in_tuser ? '0 : c_r;
    par = py[0];
    x14 = CMPW'(px);
    y14 = CMPW'(py);
    z14 = CMPW'(pz);
    c14 = CMPW'(pc);
    cx  = x14 - CMPW'(1);
    emit = (x14 >= CMPW'(1)) && (c14 < nc) &&
           (cx >= mg) && (cx + mg <= sx - CMPW'(1)) &&
           (y14 >= mg) && (y14 + mg <= sy - CMPW'(1)) &&
           (z14 >= mg) && (z14 + mg <= sz - CMPW'(1));
    last = (cx == sx - CMPW'(1) - mg) && (y14 == sy - CMPW'(1) - mg) &&
           (z14 == sz - CMPW'(1) - mg) && (c14 == nc - CMPW'(1));
    x_nxt = px;
    y_nxt = py;
    z_nxt = pz;
    c_nxt = pc + CW'(1);
    if (c14 + CMPW'(1) >= nc) begin
      c_nxt = '0;
      z_nxt = pz + ZW'(1);
      if (z14 + CMPW'(1) >= sz) begin
        z_nxt = '0;
        y_nxt = py + YW'(1);
        if (y14 + CMPW'(1) >= sy) begin
          y_nxt = '0;
          x_nxt = px + XW'(1);
          if (x14 + CMPW'(1) >= sx) begin
            x_nxt = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
      z_r <= '0;
      c_r <= '0;
    end else if (acc) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      c_r <= c_nxt;
    end
  end

  // Plane buffer, split into even and odd rows.
  function automatic logic [AW-1:0] mk_addr(logic slot, logic [YW-1:0] yv, logic [ZW-1:0] zv,
                                            logic [CW-1:0] cv);
    return {slot, yv[YW-1:1], zv, cv};
  endfunction

  logic [AW-1:0] a_lead, a_cur, a_z0, a_ym, a_yp, a_bsel;
  logic [AW-1:0] ra0, rb0, ra1, rb1;
  always_comb begin
    a_lead = mk_addr(~px[0], py, pz + ZW'(1), pc);
    a_cur  = mk_addr(px[0], py, pz, pc);
    a_z0   = mk_addr(~px[0], py, '0, pc);
    a_ym   = mk_addr(~px[0], py - YW'(1), pz, pc);
    a_yp   = mk_addr(~px[0], py + YW'(1), pz, pc);
    a_bsel = (pz == '0) ? a_z0 : a_cur;
    ra0    = par ? a_ym : a_lead;
    rb0    = par ? a_yp : a_bsel;
    ra1    = par ? a_lead : a_ym;
    rb1    = par ? a_bsel : a_yp;
  end

  logic [SW-1:0] mem0 [DEP];
  logic [SW-1:0] mem1 [DEP];
  logic [SW-1:0] m0a_r, m0b_r, m1a_r, m1b_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      m0a_r <= mem0[ra0];
      m0b_r <= mem0[rb0];
      if (!par) begin
        mem0[a_cur] <= s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      m1a_r <= mem1[ra1];
      m1b_r <= mem1[rb1];
      if (par) begin
        mem1[a_cur] <= s;
      end
    end
  end

  // Stage A: memory data in hand.
  logic          a_v_r, a_emit_r, a_last_r, a_par_r, a_z0_r;
  logic [SW-1:0] a_s_r;
  logic [XW-1:0] a_x_r;
  logic [YW-1:0] a_y_r;
  logic [ZW-1:0] a_z_r;
  logic [CW-1:0] a_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_emit_r <= emit;
      a_last_r <= last;
      a_par_r  <= par;
      a_z0_r   <= (pz == '0);
      a_s_r    <= s;
      a_x_r    <= cx[XW-1:0];
      a_y_r    <= py;
      a_z_r    <= pz;
      a_c_r    <= pc;
    end
  end

  logic [SW-1:0] lead, xm, ym, yp, ctr, zm;
  logic [SW-1:0] ln1_r [MAX_COMPONENTS];
  logic [SW-1:0] ln2_r [MAX_COMPONENTS];
  logic [CW-1:0] nci;

  always_comb begin
    lead = a_par_r ? m1a_r : m0a_r;
    xm   = a_par_r ? m1b_r : m0b_r;
    ym   = a_par_r ? m0a_r : m1a_r;
    yp   = a_par_r ? m0b_r : m1b_r;
    ctr  = ln1_r[0];
    zm   = ln2_r[0];
    nci  = CW'(nc - CMPW'(1));
  end

  // Delay lines of one site: the lead row value becomes the center, then the z-minus value.
  always_ff @(posedge clk) begin
    if (a_v_r && en) begin
      for (int i = 0; i < int'(MAX_COMPONENTS); i++) begin
        if (i == int'(nci)) begin
          ln1_r[i] <= lead;
          ln2_r[i] <= a_z0_r ? xm : ln1_r[0];
        end else if (i < int'(nci) && i + 1 < int'(MAX_COMPONENTS)) begin
          ln1_r[i] <= ln1_r[i+1];
          ln2_r[i] <= ln2_r[i+1];
        end
      end
    end
  end

  // Stage B: differences and partial sums.
  logic                 b_v_r, b_last_r;
  logic [XW-1:0]        b_x_r;
  logic [YW-1:0]        b_y_r;
  logic [ZW-1:0]        b_z_r;
  logic [CW-1:0]        b_c_r;
  logic [SW:0]          gx_r, gy_r, gz_r, sa_r, sb_r, sc_r;
  logic [SW+2:0]        c6_r, ctr3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r && a_emit_r;
    end
  end

  assign ctr3 = {{3{ctr[SW-1]}}, ctr};

  always_ff @(posedge clk) begin
    if (en) begin
      b_last_r <= a_last_r;
      b_x_r    <= a_x_r;
      b_y_r    <= a_y_r;
      b_z_r    <= a_z_r;
      b_c_r    <= a_c_r;
      gx_r     <= {a_s_r[SW-1], a_s_r} - {xm[SW-1], xm};
      gy_r     <= {yp[SW-1], yp} - {ym[SW-1], ym};
      gz_r     <= {lead[SW-1], lead} - {zm[SW-1], zm};
      sa_r     <= {a_s_r[SW-1], a_s_r} + {xm[SW-1], xm};
      sb_r     <= {yp[SW-1], yp} + {ym[SW-1], ym};
      sc_r     <= {lead[SW-1], lead} + {zm[SW-1], zm};
      c6_r     <= (ctr3 << 2) + (ctr3 << 1);
    end
  end

  // Output register.
  logic                 o_last_r;
  logic [XW-1:0]        o_x_r;
  logic [YW-1:0]        o_y_r;
  logic [ZW-1:0]        o_z_r;
  logic [CW-1:0]        o_c_r;
  logic [SW:0]          o_gx_r, o_gy_r, o_gz_r;
  logic [SW+3:0]        o_lap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_last_r <= b_last_r;
      o_x_r    <= b_x_r;
      o_y_r    <= b_y_r;
      o_z_r    <= b_z_r;
      o_c_r    <= b_c_r;
      o_gx_r   <= gx_r;
      o_gy_r   <= gy_r;
      o_gz_r   <= gz_r;
      o_lap_r  <= {{3{sa_r[SW]}}, sa_r} + {{3{sb_r[SW]}}, sb_r} + {{3{sc_r[SW]}}, sc_r}
                  - {c6_r[SW+2], c6_r};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = OW'({o_lap_r, o_gz_r, o_gy_r, o_gx_r, o_c_r, o_z_r, o_y_r, o_x_r});

  a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tuser |=> a_z_r == '0 && a_y_r == '0 && a_c_r == '0)
    else $error("start transfer did not restart the position");

  a_emit_comp: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r && a_emit_r |-> CMPW'(a_c_r) < nc)
    else $error("result for a component outside the configured count");

  a_last_comp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> CMPW'(o_c_r) == nc - CMPW'(1))
    else $error("final result not on the last component");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    b_v_r && !en |=> b_v_r)
    else $error("pipeline lost a result during a stall");

endmodule

// ----- bench/tb_stencil_gradient_laplacian_3d.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the streaming 3D gradient and Laplacian stencil.
module tb_stencil_gradient_laplacian_3d;
  import sgl3d_pkg::*;

  localparam logic [CFG_AW-1:0] CFG_UNUSED = 3'd5;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [11:0]        pos_x;
    logic [5:0]         pos_y;
    logic [5:0]         pos_z;
    logic [1:0]         component;
    logic signed [32:0] grad_x;
    logic signed [32:0] grad_y;
    logic signed [32:0] grad_z;
    logic signed [35:0] laplacian;
    logic               last;
  } site_result_t;

  typedef struct {
    int unsigned sx;
    int unsigned sy;
    int unsigned sz;
    int unsigned mg;
    int unsigned nc;
    int unsigned grids;
    int unsigned idle_pct;
    int unsigned stall_pct;
  } phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = CFG_SIZE_X;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [167:0] out_tdata;
  logic out_tlast;

  stencil_gradient_laplacian_3d dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #2 clk = ~clk;

  // Shadow of the block: registers as written, raster position and the two-plane buffer.
  int unsigned reg_sx = 3, reg_sy = 3, reg_sz = 3, reg_mg = 1, reg_nc = 1;
  int unsigned pos_x = 0, pos_y = 0, pos_z = 0, pos_c = 0;
  logic signed [31:0] plane_mem [0:32767];
  site_result_t pending_sites [$];

  int unsigned errors = 0;
  int unsigned samples_sent = 0;
  int unsigned sites_checked = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;
  site_result_t got_site, want_site;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int unsigned plane_addr(int unsigned slot, int unsigned y,
                                             int unsigned z, int unsigned c);
    return (((slot & 1) * 64 + y) * 64 + z) * 4 + c;
  endfunction

  function automatic void advance_stencil(logic [31:0] sample, bit start);
    int unsigned sx, sy, sz, mg, nc, x, y, z, c, cx, cur, prv;
    longint xm, xp, ctr, ym, yp, zm, zp;
    site_result_t r;
    sx = clampu(reg_sx, 3, 4096);
    sy = clampu(reg_sy, 3, 64);
    sz = clampu(reg_sz, 3, 64);
    mg = clampu(reg_mg, 1, 8);
    nc = clampu(reg_nc, 1, 4);
    if (start) begin
      pos_x = 0; pos_y = 0; pos_z = 0; pos_c = 0;
    end
    x = pos_x; y = pos_y; z = pos_z; c = pos_c;
    cur = x & 1;
    prv = (x + 1) & 1;
    if (x >= 1 && c < nc) begin
      cx = x - 1;
      if (cx >= mg && cx + mg <= sx - 1 && y >= mg && y + mg <= sy - 1 &&
          z >= mg && z + mg <= sz - 1) begin
        xm = plane_mem[plane_addr(cur, y, z, c)];
        xp = $signed(sample);
        ctr = plane_mem[plane_addr(prv, y, z, c)];
        ym = plane_mem[plane_addr(prv, y - 1, z, c)];
        yp = plane_mem[plane_addr(prv, y + 1, z, c)];
        zm = plane_mem[plane_addr(prv, y, z - 1, c)];
        zp = plane_mem[plane_addr(prv, y, z + 1, c)];
        r.pos_x = cx[11:0];
        r.pos_y = y[5:0];
        r.pos_z = z[5:0];
        r.component = c[1:0];
        r.grad_x = 33'(xp - xm);
        r.grad_y = 33'(yp - ym);
        r.grad_z = 33'(zp - zm);
        r.laplacian = 36'(xp + xm + yp + ym + zp + zm - 6 * ctr);
        r.last = (cx == sx - 1 - mg) && (y == sy - 1 - mg) && (z == sz - 1 - mg) &&
                 (c == nc - 1);
        pending_sites.push_back(r);
      end
    end
    plane_mem[plane_addr(cur, y, z, c)] = sample;
    c++;
    if (c >= nc) begin
      c = 0; z++;
      if (z >= sz) begin
        z = 0; y++;
        if (y >= sy) begin
          y = 0; x++;
          if (x >= sx) x = 0;
        end
      end
    end
    pos_x = x & 12'hFFF; pos_y = y; pos_z = z; pos_c = c;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Sends one sample and returns after its transfer.
  task automatic send_sample(logic [31:0] sample, bit start);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= sample;
    in_tuser <= start;
    do @(posedge clk); while (!in_tready);
    advance_stencil(sample, start);
    samples_sent++;
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, int unsigned value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value[CFG_DW-1:0];
    @(posedge clk);
    case (idx)
      CFG_SIZE_X:     reg_sx = value & 13'h1FFF;
      CFG_SIZE_Y:     reg_sy = value & 7'h7F;
      CFG_SIZE_Z:     reg_sz = value & 7'h7F;
      CFG_MARGIN:     reg_mg = value & 4'hF;
      CFG_COMPONENTS: reg_nc = value & 3'h7;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_sites.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] random_sample();
    case ($urandom_range(3))
      0: return 32'h8000_0000 ^ ($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0);
      1: return 32'($signed($urandom_range(2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_phase(phase_t p);
    int unsigned grid_len, i, g;
    bit start;
    wait_drained();
    write_reg(CFG_SIZE_X, p.sx);
    write_reg(CFG_SIZE_Y, p.sy);
    write_reg(CFG_SIZE_Z, p.sz);
    write_reg(CFG_MARGIN, p.mg);
    write_reg(CFG_COMPONENTS, p.nc);
    write_reg(CFG_UNUSED, $urandom_range(8191));
    cfg_we <= 1'b0;
    idle_pct = p.idle_pct;
    stall_pct = p.stall_pct;
    grid_len = clampu(p.sx, 3, 4096) * clampu(p.sy, 3, 64) * clampu(p.sz, 3, 64) *
               clampu(p.nc, 1, 4);
    for (g = 0; g < p.grids; g++) begin
      i = 0;
      while (i < grid_len) begin
        if (i == 0) begin
          start = (g == 0) ? 1'b1 : 1'($urandom_range(1));
        end else if (grid_len < 1000 && $urandom_range(199) == 0) begin
          // An aborted grid: restart from the first site.
          start = 1'b1;
          i = 0;
        end else begin
          start = 1'b0;
        end
        send_sample(random_sample(), start);
        i++;
      end
    end
  endtask

  // Receiver: random back-pressure and the result check.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      sites_checked++;
      got_site.pos_x = out_tdata[11:0];
      got_site.pos_y = out_tdata[17:12];
      got_site.pos_z = out_tdata[23:18];
      got_site.component = out_tdata[25:24];
      got_site.grad_x = out_tdata[58:26];
      got_site.grad_y = out_tdata[91:59];
      got_site.grad_z = out_tdata[124:92];
      got_site.laplacian = out_tdata[160:125];
      got_site.last = out_tlast;
      if (pending_sites.size() == 0) begin
        flag_mismatch($sformatf("unexpected result at site (%0d,%0d,%0d)",
                                got_site.pos_x, got_site.pos_y, got_site.pos_z));
      end else begin
        want_site = pending_sites.pop_front();
        if (got_site.pos_x !== want_site.pos_x)
          flag_mismatch($sformatf("pos_x %0d, want %0d", got_site.pos_x, want_site.pos_x));
        if (got_site.pos_y !== want_site.pos_y)
          flag_mismatch($sformatf("pos_y %0d, want %0d", got_site.pos_y, want_site.pos_y));
        if (got_site.pos_z !== want_site.pos_z)
          flag_mismatch($sformatf("pos_z %0d, want %0d", got_site.pos_z, want_site.pos_z));
        if (got_site.component !== want_site.component)
          flag_mismatch($sformatf("component %0d, want %0d", got_site.component,
                                  want_site.component));
        if (got_site.grad_x !== want_site.grad_x)
          flag_mismatch($sformatf("grad_x %0h, want %0h", got_site.grad_x, want_site.grad_x));
        if (got_site.grad_y !== want_site.grad_y)
          flag_mismatch($sformatf("grad_y %0h, want %0h", got_site.grad_y, want_site.grad_y));
        if (got_site.grad_z !== want_site.grad_z)
          flag_mismatch($sformatf("grad_z %0h, want %0h", got_site.grad_z, want_site.grad_z));
        if (got_site.laplacian !== want_site.laplacian)
          flag_mismatch($sformatf("laplacian %0h, want %0h", got_site.laplacian,
                                  want_site.laplacian));
        if (got_site.last !== want_site.last)
          flag_mismatch($sformatf("last %0b, want %0b", got_site.last, want_site.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_stencil_gradient_laplacian_3d NOT OK");
      $finish;
    end
  end

  // Reset-value grid: the centre is the most negative sample, its six neighbors the most
  // positive, so the Laplacian reaches its upper extreme and all differences are zero.
  logic [31:0] directed_grid [0:26] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF,
    32'h1234_5678, 32'hFFFF_0000, 32'h0000_0002, 32'h8000_0001,
    32'h0000_0003, 32'h7FFF_FFFF, 32'h0000_0004, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h7FFF_FFFF, 32'h0000_0005, 32'h7FFF_FFFF, 32'h0000_0006,
    32'h0000_0007, 32'h0000_0008, 32'h0000_0009, 32'h0000_000A, 32'h7FFF_FFFF,
    32'h0000_000B, 32'h0000_000C, 32'h0000_000D, 32'h0000_000E
  };
  localparam int unsigned DIRECTED_CHECK_ROW = 22;
  localparam site_result_t DIRECTED_SITE = '{
    pos_x: 12'd1, pos_y: 6'd1, pos_z: 6'd1, component: 2'd0,
    grad_x: 33'sd0, grad_y: 33'sd0, grad_z: 33'sd0,
    laplacian: 36'sd25769803770, last: 1'b1
  };

  phase_t phases [7] = '{
    '{4, 4, 4, 1, 1, 3, 0, 0},
    '{6, 5, 5, 2, 2, 1, 77, 0},
    '{5, 3, 7, 1, 4, 1, 0, 77},
    '{0, 127, 3, 0, 0, 1, 36, 36},
    '{8191, 3, 3, 1, 1, 1, 0, 0},
    '{4, 4, 4, 15, 7, 1, 36, 36},
    '{3, 3, 64, 1, 3, 1, 77, 77}
  };

  initial begin
    int unsigned row, k;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (row = 0; row < 27; row++) begin
      send_sample(directed_grid[row], row == 0);
      if (row == DIRECTED_CHECK_ROW) begin
        void'(pending_sites.pop_back());
        pending_sites.push_back(DIRECTED_SITE);
      end
    end
    for (k = 0; k < 7; k++) run_phase(phases[k]);
    wait_drained();
    $display("Streamed %0d samples over eight grid settings and checked %0d stencil results.",
             samples_sent, sites_checked);
    $display("Settings covered clamped registers, margins with no site, and random stalls.");
    if (errors == 0) begin
      $display("tb_stencil_gradient_laplacian_3d OK");
    end else begin
      $display("tb_stencil_gradient_laplacian_3d NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/sgl3d_pkg.sv
sv/stencil_gradient_laplacian_3d.sv
bench/tb_stencil_gradient_laplacian_3d.sv
